// ===== rtl/bts_pkg.sv =====
// types, codes and melody tables shared by the tone sequencer
package bts_pkg;

    // item operation codes
    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_BEEP     = 3'd1,
        OP_CLICK    = 3'd2,
        OP_START    = 3'd3,
        OP_STOP     = 3'd4,
        OP_COMPLETE = 3'd5,
        OP_ERROR    = 3'd6,
        OP_NONE     = 3'd7
    } op_t;

    // machine status codes
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_WINDING = 3'd1;
    localparam logic [2:0] ST_PAUSED  = 3'd2;
    localparam logic [2:0] ST_ERROR   = 3'd3;
    localparam logic [2:0] ST_ESTOP   = 3'd4;

    // preset melodies; the queue only ever holds the tail of one of them
    typedef enum logic [1:0] {
        MEL_START    = 2'd0,
        MEL_COMPLETE = 2'd1,
        MEL_ERROR    = 2'd2
    } melody_t;

    typedef struct packed {
        logic [15:0] freq;
        logic [15:0] ms;
    } note_t;

    // fixed single notes
    localparam note_t CLICK_NOTE = '{freq: 16'd2000, ms: 16'd20};
    localparam note_t STOP_NOTE  = '{freq: 16'd600,  ms: 16'd200};

    // sequencer state carried between beats
    typedef struct packed {
        logic        playing;
        logic [15:0] remaining_ms;
        logic [15:0] drive_freq;
        logic [2:0]  last_status;
        logic [1:0]  read_slot;
        logic [1:0]  write_slot;
        melody_t     melody;
    } state_t;

    // note at a position of a preset melody
    function automatic note_t melody_note(melody_t mel, logic [1:0] idx);
        note_t n;
        n = '{freq: 16'd0, ms: 16'd0};
        case (mel)
            MEL_START: begin
                case (idx)
                    2'd0:    n = '{freq: 16'd800,  ms: 16'd80};
                    2'd1:    n = '{freq: 16'd1200, ms: 16'd80};
                    default: n = '{freq: 16'd1600, ms: 16'd120};
                endcase
            end
            MEL_COMPLETE: begin
                case (idx)
                    2'd0:    n = '{freq: 16'd1000, ms: 16'd120};
                    2'd1:    n = '{freq: 16'd1200, ms: 16'd120};
                    2'd2:    n = '{freq: 16'd1500, ms: 16'd120};
                    default: n = '{freq: 16'd2000, ms: 16'd250};
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    n = '{freq: 16'd400, ms: 16'd300};
                    default: n = '{freq: 16'd200, ms: 16'd400};
                endcase
            end
        endcase
        return n;
    endfunction

    // index of the last note of a preset melody (queue fill after start)
    function automatic logic [1:0] melody_last(melody_t mel);
        logic [1:0] r;
        case (mel)
            MEL_START:    r = 2'd2;
            MEL_COMPLETE: r = 2'd3;
            default:      r = 2'd1;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/bts_update.sv =====
// next-state logic of the tone sequencer for one beat
module bts_update (
    input  bts_pkg::state_t cur,
    input  logic [2:0]      op,
    input  logic [15:0]     beep_freq,
    input  logic [15:0]     beep_ms,
    input  logic [2:0]      machine_status,
    input  logic            sound_enable,
    output bts_pkg::state_t nxt
);

    logic              set_go;
    bts_pkg::melody_t  set_mel;
    logic              single_go;
    bts_pkg::note_t    single_note;
    bts_pkg::note_t    pop_note;
    bts_pkg::note_t    first_note;
    logic [15:0]       rem_dec;
    logic              status_change;

    // countdown and the note that follows in the queue
    assign rem_dec       = (cur.remaining_ms != 16'd0) ? cur.remaining_ms - 16'd1 : 16'd0;
    assign pop_note      = bts_pkg::melody_note(cur.melody, cur.read_slot + 2'd1);
    assign first_note    = bts_pkg::melody_note(set_mel, 2'd0);
    assign status_change = (machine_status != cur.last_status);

    // decode which melody or single note this beat starts
    always_comb
    begin
        set_go      = 1'b0;
        set_mel     = bts_pkg::MEL_START;
        single_go   = 1'b0;
        single_note = bts_pkg::CLICK_NOTE;
        case (bts_pkg::op_t'(op))
            bts_pkg::OP_TICK:
            begin
                if (status_change)
                begin
                    if (machine_status == bts_pkg::ST_WINDING
                        && cur.last_status != bts_pkg::ST_PAUSED)
                    begin
                        set_go  = 1'b1;
                        set_mel = bts_pkg::MEL_START;
                    end
                    else if (machine_status == bts_pkg::ST_IDLE
                             && cur.last_status == bts_pkg::ST_WINDING)
                    begin
                        set_go  = 1'b1;
                        set_mel = bts_pkg::MEL_COMPLETE;
                    end
                    else if (machine_status == bts_pkg::ST_ERROR
                             || machine_status == bts_pkg::ST_ESTOP)
                    begin
                        set_go  = 1'b1;
                        set_mel = bts_pkg::MEL_ERROR;
                    end
                end
            end
            bts_pkg::OP_BEEP:
            begin
                single_go   = 1'b1;
                single_note = '{freq: beep_freq, ms: beep_ms};
            end
            bts_pkg::OP_CLICK:
            begin
                single_go   = 1'b1;
                single_note = bts_pkg::CLICK_NOTE;
            end
            bts_pkg::OP_STOP:
            begin
                single_go   = 1'b1;
                single_note = bts_pkg::STOP_NOTE;
            end
            bts_pkg::OP_START:
            begin
                set_go  = 1'b1;
                set_mel = bts_pkg::MEL_START;
            end
            bts_pkg::OP_COMPLETE:
            begin
                set_go  = 1'b1;
                set_mel = bts_pkg::MEL_COMPLETE;
            end
            bts_pkg::OP_ERROR:
            begin
                set_go  = 1'b1;
                set_mel = bts_pkg::MEL_ERROR;
            end
            default:
            begin
                set_go = 1'b0;
            end
        endcase
    end

    // state update: tick note handling first, then any new tone
    always_comb
    begin
        nxt = cur;
        if (bts_pkg::op_t'(op) == bts_pkg::OP_TICK)
        begin
            if (cur.playing)
            begin
                nxt.remaining_ms = rem_dec;
                if (rem_dec == 16'd0)
                begin
                    if (cur.read_slot != cur.write_slot)
                    begin
                        nxt.read_slot    = cur.read_slot + 2'd1;
                        nxt.drive_freq   = pop_note.freq;
                        nxt.remaining_ms = pop_note.ms;
                    end
                    else
                    begin
                        nxt.drive_freq   = 16'd0;
                        nxt.remaining_ms = 16'd0;
                        nxt.playing      = 1'b0;
                    end
                end
            end
            nxt.last_status = machine_status;
        end

        // preset melody: queue holds the tail, first note plays now if sound is enabled
        if (set_go)
        begin
            nxt.melody     = set_mel;
            nxt.read_slot  = 2'd0;
            nxt.write_slot = bts_pkg::melody_last(set_mel);
            if (sound_enable)
            begin
                nxt.drive_freq   = first_note.freq;
                nxt.remaining_ms = first_note.ms;
                nxt.playing      = 1'b1;
            end
        end

        // single note: queue emptied
        if (single_go)
        begin
            nxt.read_slot  = 2'd0;
            nxt.write_slot = 2'd0;
            if (sound_enable)
            begin
                nxt.drive_freq   = single_note.freq;
                nxt.remaining_ms = single_note.ms;
                nxt.playing      = 1'b1;
            end
        end
    end

endmodule

// ===== rtl/buzzer_tone_sequencer_core.sv =====
// top level of the buzzer tone sequencer
//
//  channel   direction  handshake          beat carries
//  in        sink       in_valid/in_stall  op, beep_freq, beep_ms, machine_status
//  out       source     out_valid/out_stall tone_freq, tone_on, queued_notes
//  cfg       sink       cfg_valid/cfg_ready cfg_data (sound enable)
//
//  one beat per cycle sustained while out_stall is low; a beat is held in the
//  input register and leaves through the result register.
//  the whole state update is one pass of next-state logic on the input register.
//  reset clears the state and both valid flags; sound is disabled after reset.
//  out_stall holds the result register and, through it, the input register.
//  queued notes are always the tail of a preset melody, so they come from a table.
module buzzer_tone_sequencer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  op,
    input  logic [15:0] beep_freq,
    input  logic [15:0] beep_ms,
    input  logic [2:0]  machine_status,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] tone_freq,
    output logic        tone_on,
    output logic [3:0]  queued_notes,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    logic            in_valid_reg;
    logic [2:0]      op_reg;
    logic [15:0]     beep_freq_reg;
    logic [15:0]     beep_ms_reg;
    logic [2:0]      status_reg;
    logic            enable_reg;
    bts_pkg::state_t state_reg;
    bts_pkg::state_t state_next;
    logic            out_valid_reg;
    logic [15:0]     tone_freq_reg;
    logic            tone_on_reg;
    logic [3:0]      queued_reg;
    logic            advance;
    logic            in_take;

    // pipeline flow
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            enable_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            enable_reg <= cfg_data;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg        <= op;
            beep_freq_reg <= beep_freq;
            beep_ms_reg   <= beep_ms;
            status_reg    <= machine_status;
        end
    end

    // next-state logic
    bts_update u_update (
        .cur            (state_reg),
        .op             (op_reg),
        .beep_freq      (beep_freq_reg),
        .beep_ms        (beep_ms_reg),
        .machine_status (status_reg),
        .sound_enable   (enable_reg),
        .nxt            (state_next)
    );

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{playing: 1'b0, remaining_ms: 16'd0, drive_freq: 16'd0,
                           last_status: bts_pkg::ST_IDLE, read_slot: 2'd0,
                           write_slot: 2'd0, melody: bts_pkg::MEL_START};
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tone_freq_reg <= state_next.drive_freq;
            tone_on_reg   <= state_next.playing;
            queued_reg    <= {2'b00, state_next.write_slot - state_next.read_slot};
        end
    end

    assign out_valid    = out_valid_reg;
    assign tone_freq    = tone_freq_reg;
    assign tone_on      = tone_on_reg;
    assign queued_notes = queued_reg;

endmodule
